@@ sv/usage_burn_rate_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// usage burn rate tracker assertion macros
// property wrappers on clock with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef USAGE_BURN_RATE_TRACKER_MACROS_SVH
`define USAGE_BURN_RATE_TRACKER_MACROS_SVH

// same-cycle implication
`define UBRT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UBRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/ubrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ubrt_pkg
// shared constants and types of the usage burn rate tracker
// ----------------------------------------------------------------------------
package ubrt_pkg;

   localparam int unsigned DEPTH_DEFAULT = 2048;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned LEVEL_W = 15;
   localparam int unsigned RATE_W  = 19;
   localparam int unsigned PROD_W  = 37;
   localparam int unsigned HI_W    = PROD_W - RATE_W;
   localparam int unsigned CNT_W   = $clog2(RATE_W + 1);
   localparam int unsigned MULT_W  = 22;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_TDATA_W = 64;

   localparam logic [MULT_W-1:0]  MS_PER_HOUR      = 22'd3600000;
   localparam logic [RATE_W-1:0]  RATE_MAX         = {RATE_W{1'b1}};
   localparam logic [TIME_W-1:0]  MIN_WINDOW_RESET = 32'd240000;
   localparam logic [LEVEL_W-1:0] RESET_DROP_RESET = 15'd1280;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_WINDOW = 2'd0,
      CSR_RESET_DROP = 2'd1,
      CSR_FROZEN     = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_ADD   = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] weekly;
      logic [LEVEL_W-1:0] session;
      logic [TIME_W-1:0]  time_ms;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

@@ sv/usage_burn_rate_tracker.sv @@
// ----------------------------------------------------------------------------
// usage_burn_rate_tracker
// sample ring with per-series window start and burn rate via serial divider
// ----------------------------------------------------------------------------
// steps: update, ring reads, then prep, multiply and divide per series, send
// no new request is taken until the response is accepted; the shared serial
//    divider does two divisions per request (19 quotient bits, one per cycle)
// reset: synchronous, empties the ring and loads register defaults at once;
//    ring contents are not cleared, there is no clearing pass
module usage_burn_rate_tracker #(
   parameter int unsigned DEPTH = ubrt_pkg::DEPTH_DEFAULT,
   localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int unsigned FILL_W = $clog2(DEPTH + 1),
   localparam int unsigned RSP_BITS = 2 * ubrt_pkg::RATE_W + 2 + FILL_W,
   localparam int unsigned RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // time_ms, session_level, weekly_level
   input  logic [ubrt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // kind
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // session_rate, session_ready, weekly_rate, weekly_ready, sample_count
   output logic [RSP_TDATA_W-1:0]             rsp_tdata,
   input  logic                               csr_wen,
   input  logic [ubrt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ubrt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_UPDATE = 11'b000_0000_0010,
      ST_RD_S   = 11'b000_0000_0100,
      ST_RD_W   = 11'b000_0000_1000,
      ST_PREP_S = 11'b000_0001_0000,
      ST_MUL_S  = 11'b000_0010_0000,
      ST_DIV_S  = 11'b000_0100_0000,
      ST_PREP_W = 11'b000_1000_0000,
      ST_MUL_W  = 11'b001_0000_0000,
      ST_DIV_W  = 11'b010_0000_0000,
      ST_SEND   = 11'b100_0000_0000
   } state_type;

   function automatic logic [SLOT_W-1:0] track_start(
      input logic [SLOT_W-1:0]            start,
      input logic [SLOT_W-1:0]            slot,
      input logic [SLOT_W-1:0]            next_slot,
      input logic [ubrt_pkg::LEVEL_W-1:0] value,
      input logic [ubrt_pkg::LEVEL_W-1:0] prev,
      input logic [ubrt_pkg::LEVEL_W-1:0] drop,
      input logic                         empty,
      input logic                         full
   );
      logic [SLOT_W-1:0]          st;
      logic [ubrt_pkg::LEVEL_W:0] sum;
      st  = start;
      sum = {1'b0, value} + {1'b0, drop};
      if (empty) begin
         st = slot;
      end else begin
         // oldest sample is about to be overwritten
         if (full && (start == slot)) begin
            st = next_slot;
         end
         if (sum < {1'b0, prev}) begin
            st = slot;
         end
      end
      return st;
   endfunction

   state_type                        state_ff, state_in;
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [SLOT_W-1:0]                s_start_ff, s_start_in;
   logic [SLOT_W-1:0]                w_start_ff, w_start_in;
   logic [ubrt_pkg::TIME_W-1:0]      min_window_ff, min_window_in;
   logic [ubrt_pkg::LEVEL_W-1:0]     drop_ff, drop_in;
   logic                             frozen_ff, frozen_in;

   ubrt_pkg::kind_type               kind_ff, kind_in;
   ubrt_pkg::entry_type              item_ff, item_in;
   ubrt_pkg::entry_type              newest_ff, newest_in;
   ubrt_pkg::entry_type              s_base_ff, s_base_in;
   ubrt_pkg::entry_type              w_base_ff, w_base_in;
   logic [ubrt_pkg::TIME_W-1:0]      dt_ff, dt_in;
   logic [ubrt_pkg::LEVEL_W-1:0]     dp_ff, dp_in;
   logic                             ok_ff, ok_in;
   logic [ubrt_pkg::RATE_W-1:0]      s_rate_ff, s_rate_in;
   logic                             s_rdy_ff, s_rdy_in;
   logic [ubrt_pkg::RATE_W-1:0]      w_rate_ff, w_rate_in;
   logic                             w_rdy_ff, w_rdy_in;

   logic [SLOT_W-1:0]                next_slot;
   logic                             empty;
   logic                             full;

   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [SLOT_W-1:0]                ram_rd_addr;
   ubrt_pkg::entry_type              ram_rd_data;

   logic                             div_start;
   logic [ubrt_pkg::PROD_W-1:0]      div_dividend;
   logic                             div_busy;
   logic [ubrt_pkg::RATE_W-1:0]      div_quotient;

   logic                             prep_weekly;
   ubrt_pkg::entry_type              prep_base;
   logic [ubrt_pkg::LEVEL_W-1:0]     prep_newest_lvl;
   logic [ubrt_pkg::LEVEL_W-1:0]     prep_base_lvl;
   logic [ubrt_pkg::TIME_W-1:0]      prep_dt;
   logic [ubrt_pkg::LEVEL_W-1:0]     prep_dp;
   logic                             prep_ok;
   logic [ubrt_pkg::RATE_W-1:0]      div_rate;

   assign next_slot = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign empty     = (fill_ff == '0);
   assign full      = (fill_ff == FILL_W'(DEPTH));

   // window operands of the series in work
   always_comb begin
      prep_weekly     = (state_ff == ST_PREP_W);
      prep_base       = prep_weekly ? w_base_ff : s_base_ff;
      prep_newest_lvl = prep_weekly ? newest_ff.weekly : newest_ff.session;
      prep_base_lvl   = prep_base_sel_lvl(prep_weekly, prep_base);
      prep_dt         = newest_ff.time_ms - prep_base.time_ms;
      prep_dp         = (prep_newest_lvl > prep_base_lvl) ? prep_newest_lvl - prep_base_lvl
                                                          : '0;
      prep_ok         = (fill_ff >= FILL_W'(2)) && (prep_dt >= min_window_ff)
                        && (prep_dt != '0);
      div_dividend    = dp_ff * ubrt_pkg::MS_PER_HOUR;
      div_rate        = ok_ff ? div_quotient : '0;
   end

   function automatic logic [ubrt_pkg::LEVEL_W-1:0] prep_base_sel_lvl(
      input logic                weekly,
      input ubrt_pkg::entry_type base
   );
      return weekly ? base.weekly : base.session;
   endfunction

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      s_start_in    = s_start_ff;
      w_start_in    = w_start_ff;
      min_window_in = min_window_ff;
      drop_in       = drop_ff;
      frozen_in     = frozen_ff;
      kind_in       = kind_ff;
      item_in       = item_ff;
      newest_in     = newest_ff;
      s_base_in     = s_base_ff;
      w_base_in     = w_base_ff;
      dt_in         = dt_ff;
      dp_in         = dp_ff;
      ok_in         = ok_ff;
      s_rate_in     = s_rate_ff;
      s_rdy_in      = s_rdy_ff;
      w_rate_in     = w_rate_ff;
      w_rdy_in      = w_rdy_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = s_start_ff;
      div_start     = 1'b0;

      if (csr_wen) begin
         unique case (csr_index)
            ubrt_pkg::CSR_MIN_WINDOW: min_window_in = csr_wdata;
            ubrt_pkg::CSR_RESET_DROP: drop_in = csr_wdata[ubrt_pkg::LEVEL_W-1:0];
            ubrt_pkg::CSR_FROZEN:     frozen_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = ubrt_pkg::kind_type'(req_tuser);
               item_in  = ubrt_pkg::entry_type'(req_tdata[ubrt_pkg::ENTRY_W-1:0]);
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (kind_ff == ubrt_pkg::KIND_CLEAR) begin
               slot_in    = '0;
               fill_in    = '0;
               s_start_in = '0;
               w_start_in = '0;
            end else if (!frozen_ff) begin
               ram_wr_en  = 1'b1;
               s_start_in = track_start(s_start_ff, slot_ff, next_slot, item_ff.session,
                                        newest_ff.session, drop_ff, empty, full);
               w_start_in = track_start(w_start_ff, slot_ff, next_slot, item_ff.weekly,
                                        newest_ff.weekly, drop_ff, empty, full);
               newest_in  = item_ff;
               slot_in    = next_slot;
               if (!full) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
            state_in = ST_RD_S;
         end
         ST_RD_S: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = s_start_ff;
            state_in    = ST_RD_W;
         end
         ST_RD_W: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = w_start_ff;
            s_base_in   = ram_rd_data;
            state_in    = ST_PREP_S;
         end
         ST_PREP_S: begin
            w_base_in = ram_rd_data;
            dt_in     = prep_dt;
            dp_in     = prep_dp;
            ok_in     = prep_ok;
            state_in  = ST_MUL_S;
         end
         ST_MUL_S: begin
            div_start = 1'b1;
            state_in  = ST_DIV_S;
         end
         ST_DIV_S: begin
            if (!div_busy) begin
               s_rate_in = div_rate;
               s_rdy_in  = ok_ff;
               state_in  = ST_PREP_W;
            end
         end
         ST_PREP_W: begin
            dt_in    = prep_dt;
            dp_in    = prep_dp;
            ok_in    = prep_ok;
            state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            div_start = 1'b1;
            state_in  = ST_DIV_W;
         end
         ST_DIV_W: begin
            if (!div_busy) begin
               w_rate_in = div_rate;
               w_rdy_in  = ok_ff;
               state_in  = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff       <= '0;
         fill_ff       <= '0;
         s_start_ff    <= '0;
         w_start_ff    <= '0;
         min_window_ff <= ubrt_pkg::MIN_WINDOW_RESET;
         drop_ff       <= ubrt_pkg::RESET_DROP_RESET;
         frozen_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         fill_ff       <= fill_in;
         s_start_ff    <= s_start_in;
         w_start_ff    <= w_start_in;
         min_window_ff <= min_window_in;
         drop_ff       <= drop_in;
         frozen_ff     <= frozen_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      item_ff   <= item_in;
      newest_ff <= newest_in;
      s_base_ff <= s_base_in;
      w_base_ff <= w_base_in;
      dt_ff     <= dt_in;
      dp_ff     <= dp_in;
      ok_ff     <= ok_in;
      s_rate_ff <= s_rate_in;
      s_rdy_ff  <= s_rdy_in;
      w_rate_ff <= w_rate_in;
      w_rdy_ff  <= w_rdy_in;
   end

   ubrt_ram #(
      .WIDTH (ubrt_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (item_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ubrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dt_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = RSP_TDATA_W'({fill_ff, w_rdy_ff, w_rate_ff, s_rdy_ff, s_rate_ff});

endmodule

@@ sv/ubrt_ram.sv @@
// ----------------------------------------------------------------------------
// ubrt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ubrt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ubrt_div.sv @@
// ----------------------------------------------------------------------------
// ubrt_div
// shared serial divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
module ubrt_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ubrt_pkg::PROD_W-1:0]     dividend,
   input  logic [ubrt_pkg::TIME_W-1:0]     divisor,
   output logic                            busy,
   output logic [ubrt_pkg::RATE_W-1:0]     quotient
);

   logic                            busy_ff, busy_in;
   logic                            chk_ff, chk_in;
   logic [ubrt_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ubrt_pkg::HI_W-1:0]       num_hi_ff, num_hi_in;
   logic [ubrt_pkg::RATE_W-1:0]     num_lo_ff, num_lo_in;
   logic [ubrt_pkg::TIME_W-1:0]     rem_ff, rem_in;
   logic [ubrt_pkg::TIME_W-1:0]     den_ff, den_in;

   logic [ubrt_pkg::TIME_W:0]       trial;
   logic [ubrt_pkg::TIME_W+1:0]     diff;
   logic                            fits;
   logic                            sat;

   always_comb begin
      trial = {rem_ff, num_lo_ff[ubrt_pkg::RATE_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
      fits  = ~diff[ubrt_pkg::TIME_W+1];
      sat   = ubrt_pkg::TIME_W'(num_hi_ff) >= den_ff;
   end

   always_comb begin
      busy_in   = busy_ff;
      chk_in    = chk_ff;
      cnt_in    = cnt_ff;
      num_hi_in = num_hi_ff;
      num_lo_in = num_lo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      priority if (start) begin
         busy_in   = 1'b1;
         chk_in    = 1'b1;
         num_hi_in = dividend[ubrt_pkg::PROD_W-1:ubrt_pkg::RATE_W];
         num_lo_in = dividend[ubrt_pkg::RATE_W-1:0];
         den_in    = divisor;
      end else if (chk_ff) begin
         chk_in = 1'b0;
         // quotient would not fit in the rate field
         if (sat) begin
            busy_in   = 1'b0;
            num_lo_in = ubrt_pkg::RATE_MAX;
         end else begin
            rem_in = ubrt_pkg::TIME_W'(num_hi_ff);
            cnt_in = ubrt_pkg::CNT_W'(ubrt_pkg::RATE_W);
         end
      end else if (busy_ff) begin
         rem_in    = fits ? diff[ubrt_pkg::TIME_W-1:0] : trial[ubrt_pkg::TIME_W-1:0];
         num_lo_in = {num_lo_ff[ubrt_pkg::RATE_W-2:0], fits};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == ubrt_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      num_hi_ff <= num_hi_in;
      num_lo_ff <= num_lo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_lo_ff;

endmodule

@@ sv/ubrt_checker.sv @@
// ----------------------------------------------------------------------------
// ubrt_checker
// port-level checks of the usage burn rate tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "usage_burn_rate_tracker_macros.svh"

module ubrt_checker #(
   parameter int unsigned DEPTH = ubrt_pkg::DEPTH_DEFAULT,
   localparam int unsigned FILL_W = $clog2(DEPTH + 1),
   localparam int unsigned RSP_BITS = 2 * ubrt_pkg::RATE_W + 2 + FILL_W,
   localparam int unsigned RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [ubrt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [RSP_TDATA_W-1:0]             rsp_tdata,
   input logic                               csr_wen,
   input logic [ubrt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic [ubrt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned S_RDY_BIT  = ubrt_pkg::RATE_W;
   localparam int unsigned W_RATE_LSB = ubrt_pkg::RATE_W + 1;
   localparam int unsigned W_RDY_BIT  = 2 * ubrt_pkg::RATE_W + 1;

   logic req_fire;
   logic rsp_fire;
   logic rsp_stall;
   logic s_idle_rate;
   logic w_idle_rate;

   assign req_fire    = req_tvalid && req_tready;
   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign s_idle_rate = (rsp_tdata[S_RDY_BIT-1:0] == '0);
   assign w_idle_rate = (rsp_tdata[W_RDY_BIT-1:W_RATE_LSB] == '0);

   `UBRT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `UBRT_ASSERT_IMPLIES(a_one_in_flight, rsp_tvalid, !req_tready, "request taken while result pending")
   `UBRT_ASSERT_NEXT(a_busy_after_req, req_fire, !req_tready && !rsp_tvalid, "block not busy after request")
   `UBRT_ASSERT_NEXT(a_idle_after_rsp, rsp_fire, req_tready && !rsp_tvalid, "block not idle after response")
   `UBRT_ASSERT_IMPLIES(a_unready_zero, rsp_tvalid && (!rsp_tdata[S_RDY_BIT] || !rsp_tdata[W_RDY_BIT]), (rsp_tdata[S_RDY_BIT] || s_idle_rate) && (rsp_tdata[W_RDY_BIT] || w_idle_rate), "rate not zero while not ready")

endmodule

bind usage_burn_rate_tracker ubrt_checker #(.DEPTH(DEPTH)) u_ubrt_checker (.*);
